// File: rtl/two_digit_counter_voltmeter_display_assert.svh
// Assertion macros for the display driver checker.
`ifndef TWO_DIGIT_COUNTER_VOLTMETER_DISPLAY_ASSERT_SVH
`define TWO_DIGIT_COUNTER_VOLTMETER_DISPLAY_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TDCVD_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define TDCVD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/tdcvd_pkg.sv
// Package: shared constants, types and segment functions of the display driver.
`default_nettype none

package tdcvd_pkg;

  localparam int unsigned AdcWidthDefault = 16;
  localparam int unsigned ScaleMul        = 33;
  localparam logic [6:0]  CounterMax      = 7'd99;
  localparam logic [3:0]  NumDigits       = 4'd10;

  localparam logic [7:0] SegTable [10] = '{
    8'h7E, 8'h0C, 8'hB6, 8'h9E, 8'hCC, 8'hDA, 8'hFA, 8'h0E, 8'hFE, 8'hCE
  };

  typedef struct packed {
    logic [3:0] hi_digit;
    logic [3:0] lo_digit;
    logic       point;
  } digits_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] pat;
    pat = 8'h00;
    if (digit < NumDigits) begin
      pat = SegTable[digit];
    end
    return pat;
  endfunction

  function automatic logic [8:0] remap_low(input logic [7:0] pat);
    return {pat[7], pat[6], 1'b0, pat[5:0]};
  endfunction

  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] prod;
    prod = {8'd0, v} * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [6:0] v);
    logic [6:0] tens;
    logic [6:0] rem;
    tens = {3'd0, div10(v)} * 7'd10;
    rem  = v - tens;
    return rem[3:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/tdcvd_step.sv
// State update and digit extraction: point toggle, counter step, sample scaling.
`default_nettype none

module tdcvd_step #(
  parameter int unsigned AdcWidth = tdcvd_pkg::AdcWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                mode_i,
  input  logic                dir_i,
  input  logic [15:0]         sample_i,
  output tdcvd_pkg::digits_t  digits_o
);

  localparam int unsigned ProdWidth = AdcWidth + 6;

  logic [6:0]           counter_q, counter_d;
  logic                 point_q, point_d;
  logic [AdcWidth-1:0]  sample;
  logic [ProdWidth-1:0] prod;
  logic [5:0]           scaled;
  logic [6:0]           counter_step;
  logic [6:0]           shown;

  assign sample = sample_i[AdcWidth-1:0];
  assign prod   = {6'd0, sample} * ProdWidth'(tdcvd_pkg::ScaleMul);
  assign scaled = prod[ProdWidth-1:AdcWidth];

  always_comb begin
    if (dir_i) begin
      counter_step = (counter_q >= tdcvd_pkg::CounterMax) ? 7'd0 : counter_q + 7'd1;
    end else begin
      counter_step = (counter_q == 7'd0) ? tdcvd_pkg::CounterMax : counter_q - 7'd1;
    end
  end

  assign counter_d = mode_i ? counter_step : counter_q;
  assign point_d   = ~point_q;
  assign shown     = mode_i ? counter_step : {1'b0, scaled};

  assign digits_o.hi_digit = tdcvd_pkg::div10(shown);
  assign digits_o.lo_digit = tdcvd_pkg::mod10(shown);
  assign digits_o.point    = point_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= 7'd0;
      point_q   <= 1'b0;
    end else if (en_i) begin
      counter_q <= counter_d;
      point_q   <= point_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tdcvd_seg.sv
// Seven-segment encoder: digit patterns, low-digit remap and decimal point.
`default_nettype none

module tdcvd_seg (
  input  tdcvd_pkg::digits_t digits_i,
  output logic [7:0]         high_seg_o,
  output logic [8:0]         low_seg_o
);

  logic [7:0] low_pat;

  assign high_seg_o = tdcvd_pkg::seg_of(digits_i.hi_digit);
  assign low_pat    = tdcvd_pkg::seg_of(digits_i.lo_digit);
  assign low_seg_o  = tdcvd_pkg::remap_low(low_pat) | {8'd0, digits_i.point};

endmodule

`default_nettype wire

// File: rtl/two_digit_counter_voltmeter_display.sv
// Top level: input register, digit logic, segment encoder and result register.
// An accepted item waits in the input register; its result is captured in the result register once the output is free.
// Throughput: one item per cycle while the output is not stalled; the single logic pass sits between two registers.
// Input stays ready while a result waits, as long as the input register is free.
// Reset clears both valid flags, the counter and the decimal-point toggle.
`default_nettype none

module two_digit_counter_voltmeter_display #(
  parameter int unsigned AdcWidth = tdcvd_pkg::AdcWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_pin_i,
  input  logic        direction_pin_i,
  input  logic [15:0] adc_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  high_digit_segments_o,
  output logic [8:0]  low_digit_segments_o
);

  logic               in_valid_q, in_valid_d;
  logic               mode_q, dir_q;
  logic [15:0]        sample_q;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         high_q;
  logic [8:0]         low_q;
  logic               in_take;
  logic               advance;
  tdcvd_pkg::digits_t digits;
  logic [7:0]         high_seg;
  logic [8:0]         low_seg;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || !out_valid_q || out_ready_i;
  assign in_take    = in_valid_i && in_ready_o;

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  tdcvd_step #(
    .AdcWidth(AdcWidth)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .mode_i   (mode_q),
    .dir_i    (dir_q),
    .sample_i (sample_q),
    .digits_o (digits)
  );

  tdcvd_seg u_seg (
    .digits_i   (digits),
    .high_seg_o (high_seg),
    .low_seg_o  (low_seg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q   <= mode_pin_i;
      dir_q    <= direction_pin_i;
      sample_q <= adc_sample_i;
    end
    if (advance) begin
      high_q <= high_seg;
      low_q  <= low_seg;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign high_digit_segments_o = high_q;
  assign low_digit_segments_o  = low_q;

endmodule

`default_nettype wire

// File: rtl/tdcvd_checker.sv
// Port checker for the display driver and its bind to the top level.
`default_nettype none
`include "two_digit_counter_voltmeter_display_assert.svh"

module tdcvd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] high_digit_segments_o,
  input logic [8:0] low_digit_segments_o
);

  `TDCVD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(high_digit_segments_o) && $stable(low_digit_segments_o))
  `TDCVD_ASSERT_NOW(a_low_gap, clk_i, rst_ni, out_valid_o, low_digit_segments_o[6] == 1'b0)
  `TDCVD_ASSERT_NOW(a_high_lsb, clk_i, rst_ni, out_valid_o, high_digit_segments_o[0] == 1'b0)
  `TDCVD_ASSERT_NOW(a_stall_only, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

endmodule

bind two_digit_counter_voltmeter_display tdcvd_checker u_tdcvd_checker (.*);

`default_nettype wire
